[hw/rtl/scn_pkg.sv]
// Shared widths, constants and helpers for the spin-1 Crank-Nicolson step.
// No dependencies; every other file in hw/rtl imports this package.
package scn_pkg;

  // Field and register widths
  localparam int AW   = 16;  // amplitude / field / result width
  localparam int GW   = 16;  // coupling gain width

  // Internal datapath widths, sized for the worst-case operand ranges
  localparam int CW   = 33;  // gain * field
  localparam int HPW  = 58;  // C * 1/sqrt(2) product before the shift
  localparam int HW   = 33;  // hx, hy
  localparam int SQPW = 66;  // C * C product
  localparam int SQW  = 44;  // C * C / 2^22
  localparam int TW   = 46;  // denominator 1 + |c|^2 at 2^-26
  localparam int PW   = 49;  // h * amplitude product
  localparam int WW   = 51;  // K * psi at 2^-38
  localparam int W19W = 32;  // K * psi at 2^-19
  localparam int QPW  = 65;  // h * w19 product
  localparam int UW   = 67;  // K * K * psi at 2^-43
  localparam int U3W  = 64;  // K * K * psi at 2^-40
  localparam int NW   = 66;  // numerator at 2^-40
  localparam int RW   = 67;  // divider remainder
  localparam int QB   = 17;  // quotient bits kept; larger quotients saturate
  localparam int XW   = AW + 3;  // width of amplitude minus quotient

  localparam logic [23:0]   INV_SQRT2_Q24 = 24'd11863283;
  localparam logic [TW-1:0] T_ONE         = TW'(64'h0000_0000_0400_0000);

  localparam logic signed [AW-1:0] AMP_MAX = 16'sh7FFF;
  localparam logic signed [AW-1:0] AMP_MIN = -16'sh8000;

  // Clamp a widened difference back to Q1.14
  function automatic logic signed [AW-1:0] sat16(input logic signed [XW-1:0] x);
    logic signed [AW-1:0] r;
    if (x > XW'(AMP_MAX)) begin
      r = AMP_MAX;
    end else if (x < XW'(AMP_MIN)) begin
      r = AMP_MIN;
    end else begin
      r = AW'(x);
    end
    return r;
  endfunction

endpackage

[hw/rtl/scn_if.sv]
// Valid/ready channel interfaces for the spin-1 step: input state + field,
// and the updated state. Depends on scn_pkg.
interface scn_in_if;
  import scn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] amp0_re;
  logic signed [AW-1:0] amp0_im;
  logic signed [AW-1:0] amp1_re;
  logic signed [AW-1:0] amp1_im;
  logic signed [AW-1:0] amp2_re;
  logic signed [AW-1:0] amp2_im;
  logic signed [AW-1:0] field_x;
  logic signed [AW-1:0] field_y;
  logic signed [AW-1:0] field_z;

  modport source (output valid, amp0_re, amp0_im, amp1_re, amp1_im, amp2_re, amp2_im,
                  field_x, field_y, field_z, input ready);
  modport sink   (input valid, amp0_re, amp0_im, amp1_re, amp1_im, amp2_re, amp2_im,
                  field_x, field_y, field_z, output ready);
endinterface

interface scn_out_if;
  import scn_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] new0_re;
  logic signed [AW-1:0] new0_im;
  logic signed [AW-1:0] new1_re;
  logic signed [AW-1:0] new1_im;
  logic signed [AW-1:0] new2_re;
  logic signed [AW-1:0] new2_im;

  modport source (output valid, new0_re, new0_im, new1_re, new1_im, new2_re, new2_im,
                  input ready);
  modport sink   (input valid, new0_re, new0_im, new1_re, new1_im, new2_re, new2_im,
                  output ready);
endinterface

[hw/rtl/spin_one_crank_nicolson_step.sv]
// One beat per cycle enters; the whole pipe advances in lockstep and
// freezes only while the output register holds a beat that is not taken.
// The depth is set by the 17-stage restoring divider, one quotient bit a stage.
// Reset (rst_n low, synchronous) clears all valid bits and the coupling gain.
// Depends on scn_pkg and scn_if.
module spin_one_crank_nicolson_step (
  input  logic                    clk,
  input  logic                    rst_n,
  scn_in_if.sink                  in_ch,
  scn_out_if.source               out_ch,
  input  logic                    cfg_we,
  input  logic [scn_pkg::GW-1:0]  cfg_wdata
);
  import scn_pkg::*;

  // Stage numbering
  localparam int ST_C   = 0;   // C = gain * field
  localparam int ST_H   = 1;   // hx, hy, squares
  localparam int ST_P   = 2;   // h * amplitude products, denominator
  localparam int ST_W   = 3;   // w = K * psi
  localparam int ST_UP  = 4;   // h * w19 products
  localparam int ST_U   = 5;   // u = K * w19 / 8
  localparam int ST_N   = 6;   // numerator
  localparam int ST_D   = 7;   // magnitude + half divisor
  localparam int ST_OV  = 8;   // quotient overflow check
  localparam int ST_DL  = ST_OV + QB;  // last quotient bit
  localparam int ST_OUT = ST_DL + 1;

  logic [GW-1:0]   gain_r;
  logic [ST_OUT:0] vld_r;
  logic            adv;

  logic signed [AW-1:0] amp_r [ST_C:ST_DL][0:5];
  logic signed [AW-1:0] in_amp [0:5];
  logic signed [AW-1:0] in_fld [0:2];

  logic signed [CW-1:0] c_r   [0:2];
  logic signed [CW-1:0] c_nxt [0:2];

  logic signed [HW-1:0]  hx_r [ST_H:ST_W];
  logic signed [HW-1:0]  hy_r [ST_H:ST_W];
  logic signed [CW-1:0]  cz_r [ST_H:ST_W];
  logic signed [HW-1:0]  hx_nxt, hy_nxt;
  logic signed [HPW-1:0] hpx, hpy;
  logic [SQW-1:0]        sq_r   [0:2];
  logic [SQW-1:0]        sq_nxt [0:2];
  logic signed [SQPW-1:0] sqp   [0:2];

  logic [TW-1:0] t_r [ST_P:ST_DL];
  logic [TW-1:0] t_nxt;

  logic signed [PW-1:0] pxr_r [0:2], pxi_r [0:2], pyr_r [0:2], pyi_r [0:2];
  logic signed [PW-1:0] pzr_r [0:1], pzi_r [0:1];
  logic signed [PW-1:0] pxr_nxt [0:2], pxi_nxt [0:2], pyr_nxt [0:2], pyi_nxt [0:2];
  logic signed [PW-1:0] pzr_nxt [0:1], pzi_nxt [0:1];

  logic signed [WW-1:0] wr_r [ST_W:ST_U][0:2];
  logic signed [WW-1:0] wi_r [ST_W:ST_U][0:2];
  logic signed [WW-1:0] wr_nxt [0:2], wi_nxt [0:2];

  logic signed [W19W-1:0] w19r [0:2], w19i [0:2];
  logic signed [QPW-1:0] qxr_r [0:2], qxi_r [0:2], qyr_r [0:2], qyi_r [0:2];
  logic signed [QPW-1:0] qzr_r [0:1], qzi_r [0:1];
  logic signed [QPW-1:0] qxr_nxt [0:2], qxi_nxt [0:2], qyr_nxt [0:2], qyi_nxt [0:2];
  logic signed [QPW-1:0] qzr_nxt [0:1], qzi_nxt [0:1];

  logic signed [UW-1:0]  usr [0:2], usi [0:2];
  logic signed [U3W-1:0] ur_r [0:2], ui_r [0:2];
  logic signed [U3W-1:0] ur_nxt [0:2], ui_nxt [0:2];

  logic signed [NW-1:0] n_r   [0:5];
  logic signed [NW-1:0] n_nxt [0:5];

  logic [RW-1:0] d_r   [0:5];
  logic          dneg_r [0:5];
  logic [RW-1:0] d_nxt [0:5];
  logic [NW-1:0] mag   [0:5];

  // Divider pipe: index 0 is the overflow stage, index i yields bit QB-i
  logic [RW-1:0] rem_r  [0:QB][0:5];
  logic [QB-1:0] quo_r  [0:QB][0:5];
  logic          ovf_r  [0:QB][0:5];
  logic          neg_r  [0:QB][0:5];
  logic [RW-1:0] big;

  logic signed [AW-1:0] res_r   [0:5];
  logic signed [AW-1:0] res_nxt [0:5];

  // Advance the whole pipe unless the output beat is stuck
  assign adv         = !vld_r[ST_OUT] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (cfg_we) begin
      gain_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[ST_OUT-1:0], in_ch.valid};
    end
  end

  assign in_amp = '{in_ch.amp0_re, in_ch.amp0_im, in_ch.amp1_re,
                    in_ch.amp1_im, in_ch.amp2_re, in_ch.amp2_im};
  assign in_fld = '{in_ch.field_x, in_ch.field_y, in_ch.field_z};

  // Stage C: scale the field by the gain
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_nxt[k] = CW'($signed({1'b0, gain_r})) * CW'(in_fld[k]);
    end
  end

  // Stage H: transverse terms times 1/sqrt(2), squares for the denominator
  always_comb begin
    hpx    = HPW'(c_r[0]) * HPW'($signed({1'b0, INV_SQRT2_Q24}));
    hpy    = HPW'(c_r[1]) * HPW'($signed({1'b0, INV_SQRT2_Q24}));
    hx_nxt = HW'(hpx >>> 24);
    hy_nxt = HW'(hpy >>> 24);
    for (int k = 0; k < 3; k++) begin
      sqp[k]    = SQPW'(c_r[k]) * SQPW'(c_r[k]);
      sq_nxt[k] = SQW'(sqp[k] >>> 22);
    end
  end

  // Stage P: h * amplitude products, sum the denominator
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pxr_nxt[j] = PW'(hx_r[ST_H]) * PW'(amp_r[ST_H][2*j]);
      pxi_nxt[j] = PW'(hx_r[ST_H]) * PW'(amp_r[ST_H][2*j+1]);
      pyr_nxt[j] = PW'(hy_r[ST_H]) * PW'(amp_r[ST_H][2*j]);
      pyi_nxt[j] = PW'(hy_r[ST_H]) * PW'(amp_r[ST_H][2*j+1]);
    end
    pzr_nxt[0] = PW'(cz_r[ST_H]) * PW'(amp_r[ST_H][0]);
    pzi_nxt[0] = PW'(cz_r[ST_H]) * PW'(amp_r[ST_H][1]);
    pzr_nxt[1] = PW'(cz_r[ST_H]) * PW'(amp_r[ST_H][4]);
    pzi_nxt[1] = PW'(cz_r[ST_H]) * PW'(amp_r[ST_H][5]);
    t_nxt = T_ONE + TW'(sq_r[0]) + TW'(sq_r[1]) + TW'(sq_r[2]);
  end

  // Stage W: w = K * psi
  always_comb begin
    wr_nxt[0] = WW'(pzr_r[0]) + WW'(pxr_r[1]) + WW'(pyi_r[1]);
    wi_nxt[0] = WW'(pzi_r[0]) + WW'(pxi_r[1]) - WW'(pyr_r[1]);
    wr_nxt[1] = WW'(pxr_r[0]) - WW'(pyi_r[0]) + WW'(pxr_r[2]) + WW'(pyi_r[2]);
    wi_nxt[1] = WW'(pxi_r[0]) + WW'(pyr_r[0]) + WW'(pxi_r[2]) - WW'(pyr_r[2]);
    wr_nxt[2] = WW'(pxr_r[1]) - WW'(pyi_r[1]) - WW'(pzr_r[1]);
    wi_nxt[2] = WW'(pxi_r[1]) + WW'(pyr_r[1]) - WW'(pzi_r[1]);
  end

  // Stage UP: h * floor(w / 2^19) products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      w19r[j]    = W19W'(wr_r[ST_W][j] >>> 19);
      w19i[j]    = W19W'(wi_r[ST_W][j] >>> 19);
      qxr_nxt[j] = QPW'(hx_r[ST_W]) * QPW'(w19r[j]);
      qxi_nxt[j] = QPW'(hx_r[ST_W]) * QPW'(w19i[j]);
      qyr_nxt[j] = QPW'(hy_r[ST_W]) * QPW'(w19r[j]);
      qyi_nxt[j] = QPW'(hy_r[ST_W]) * QPW'(w19i[j]);
    end
    qzr_nxt[0] = QPW'(cz_r[ST_W]) * QPW'(w19r[0]);
    qzi_nxt[0] = QPW'(cz_r[ST_W]) * QPW'(w19i[0]);
    qzr_nxt[1] = QPW'(cz_r[ST_W]) * QPW'(w19r[2]);
    qzi_nxt[1] = QPW'(cz_r[ST_W]) * QPW'(w19i[2]);
  end

  // Stage U: u = K * w19, dropped to 2^-40
  always_comb begin
    usr[0] = UW'(qzr_r[0]) + UW'(qxr_r[1]) + UW'(qyi_r[1]);
    usi[0] = UW'(qzi_r[0]) + UW'(qxi_r[1]) - UW'(qyr_r[1]);
    usr[1] = UW'(qxr_r[0]) - UW'(qyi_r[0]) + UW'(qxr_r[2]) + UW'(qyi_r[2]);
    usi[1] = UW'(qxi_r[0]) + UW'(qyr_r[0]) + UW'(qxi_r[2]) - UW'(qyr_r[2]);
    usr[2] = UW'(qxr_r[1]) - UW'(qyi_r[1]) - UW'(qzr_r[1]);
    usi[2] = UW'(qxi_r[1]) + UW'(qyr_r[1]) - UW'(qzi_r[1]);
    for (int j = 0; j < 3; j++) begin
      ur_nxt[j] = U3W'(usr[j] >>> 3);
      ui_nxt[j] = U3W'(usi[j] >>> 3);
    end
  end

  // Stage N: numerator 2*(i*w + u) at 2^-40
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n_nxt[2*j]   = (NW'(ur_r[j]) - (NW'(wi_r[ST_U][j]) <<< 2)) <<< 1;
      n_nxt[2*j+1] = (NW'(ui_r[j]) + (NW'(wr_r[ST_U][j]) <<< 2)) <<< 1;
    end
  end

  // Stage D: magnitude plus half the divisor, for round-half-away
  always_comb begin
    for (int l = 0; l < 6; l++) begin
      mag[l]   = n_r[l][NW-1] ? NW'(-n_r[l]) : NW'(n_r[l]);
      d_nxt[l] = RW'(mag[l]) + RW'(t_r[ST_N] >> 1);
    end
  end

  assign big = RW'(t_r[ST_D]) << QB;

  // Main register bank for the arithmetic stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 6; l++) begin
        amp_r[ST_C][l] <= in_amp[l];
      end
      for (int s = ST_C + 1; s <= ST_DL; s++) begin
        amp_r[s] <= amp_r[s-1];
      end
      c_r <= c_nxt;

      hx_r[ST_H] <= hx_nxt;
      hy_r[ST_H] <= hy_nxt;
      cz_r[ST_H] <= c_r[2];
      for (int s = ST_H + 1; s <= ST_W; s++) begin
        hx_r[s] <= hx_r[s-1];
        hy_r[s] <= hy_r[s-1];
        cz_r[s] <= cz_r[s-1];
      end
      sq_r <= sq_nxt;

      t_r[ST_P] <= t_nxt;
      for (int s = ST_P + 1; s <= ST_DL; s++) begin
        t_r[s] <= t_r[s-1];
      end
      pxr_r <= pxr_nxt;
      pxi_r <= pxi_nxt;
      pyr_r <= pyr_nxt;
      pyi_r <= pyi_nxt;
      pzr_r <= pzr_nxt;
      pzi_r <= pzi_nxt;

      wr_r[ST_W] <= wr_nxt;
      wi_r[ST_W] <= wi_nxt;
      for (int s = ST_W + 1; s <= ST_U; s++) begin
        wr_r[s] <= wr_r[s-1];
        wi_r[s] <= wi_r[s-1];
      end

      qxr_r <= qxr_nxt;
      qxi_r <= qxi_nxt;
      qyr_r <= qyr_nxt;
      qyi_r <= qyi_nxt;
      qzr_r <= qzr_nxt;
      qzi_r <= qzi_nxt;

      ur_r <= ur_nxt;
      ui_r <= ui_nxt;
      n_r  <= n_nxt;

      for (int l = 0; l < 6; l++) begin
        d_r[l]    <= d_nxt[l];
        dneg_r[l] <= n_r[l][NW-1];
        // Overflow stage: a quotient of 2^QB or more saturates for sure
        rem_r[0][l] <= d_r[l];
        quo_r[0][l] <= '0;
        ovf_r[0][l] <= (d_r[l] >= big);
        neg_r[0][l] <= dneg_r[l];
      end
      res_r <= res_nxt;
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar i = 1; i <= QB; i++) begin : g_div
    logic [RW-1:0] shd;
    logic [RW-1:0] rem_nxt [0:5];
    logic [QB-1:0] quo_nxt [0:5];

    assign shd = RW'(t_r[ST_OV + i - 1]) << (QB - i);

    always_comb begin
      for (int l = 0; l < 6; l++) begin
        quo_nxt[l] = quo_r[i-1][l];
        if (rem_r[i-1][l] >= shd) begin
          rem_nxt[l]        = rem_r[i-1][l] - shd;
          quo_nxt[l][QB-i]  = 1'b1;
        end else begin
          rem_nxt[l] = rem_r[i-1][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= rem_nxt;
        quo_r[i] <= quo_nxt;
        ovf_r[i] <= ovf_r[i-1];
        neg_r[i] <= neg_r[i-1];
      end
    end
  end

  // Output stage: subtract the signed quotient and saturate
  always_comb begin
    logic signed [XW-1:0] qs;
    for (int l = 0; l < 6; l++) begin
      qs = neg_r[QB][l] ? -XW'($signed({1'b0, quo_r[QB][l]}))
                        :  XW'($signed({1'b0, quo_r[QB][l]}));
      if (ovf_r[QB][l]) begin
        res_nxt[l] = neg_r[QB][l] ? AMP_MAX : AMP_MIN;
      end else begin
        res_nxt[l] = sat16(XW'(amp_r[ST_DL][l]) - qs);
      end
    end
  end

  assign out_ch.valid   = vld_r[ST_OUT];
  assign out_ch.new0_re = res_r[0];
  assign out_ch.new0_im = res_r[1];
  assign out_ch.new1_re = res_r[2];
  assign out_ch.new1_im = res_r[3];
  assign out_ch.new2_re = res_r[4];
  assign out_ch.new2_im = res_r[5];

  // Denominator never drops below one
  a_t_min: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_P] |-> t_r[ST_P] >= T_ONE)
    else $error("denominator below one");

  // Without overflow the lane-0 dividend fits the kept quotient bits
  a_ovf_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_OV] && !ovf_r[0][0] |-> rem_r[0][0] < (RW'(t_r[ST_OV]) << QB))
    else $error("overflow check missed");

  // Final remainder of lane 5 is below the divisor
  a_rem_final: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_DL] && !ovf_r[QB][5] |-> rem_r[QB][5] < RW'(t_r[ST_DL]))
    else $error("divider remainder too large");

  // A new output beat comes from the stage just before it
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r[ST_OUT]) |-> $past(vld_r[ST_OUT-1]))
    else $error("output beat from nowhere");

endmodule
